// File: rtl/core/mpre_pkg.sv
// Shared types and constants for the mono page to RGB565 expander.
package mpre_pkg;

  localparam int PANEL_COLUMNS = 96;
  localparam int PANEL_ROWS    = 64;
  localparam int PANEL_PAGES   = PANEL_ROWS / 8;

  // Request codes
  localparam logic [1:0] REQ_SET_WINDOW = 2'd0;
  localparam logic [1:0] REQ_WRITE_BYTE = 2'd1;
  localparam logic [1:0] REQ_SCROLL     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_FOREGROUND = 2'd0;
  localparam logic [1:0] REG_BACKGROUND = 2'd1;
  localparam logic [1:0] REG_ROW_OFFSET = 2'd2;

  // Word positions within a write-byte command
  localparam logic [3:0] STEP_PRE         = 4'd0;
  localparam logic [3:0] STEP_FIRST_PIXEL = 4'd1;
  localparam logic [3:0] STEP_LAST_PIXEL  = 4'd8;
  localparam logic [3:0] STEP_POST        = 4'd9;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [6:0]        window_left;
    logic [2:0]        window_top_page;
    logic [6:0]        window_right;
    logic [2:0]        window_bottom_page;
    logic [7:0]        pixel_byte;
    logic signed [7:0] scroll_pages;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] pixel_color;
    logic [6:0]  out_left;
    logic [6:0]  out_right;
    logic [5:0]  out_top_row;
    logic [6:0]  out_bottom_row;
    logic [5:0]  out_start_line;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] foreground_color;
    logic [15:0] background_color;
    logic [5:0]  row_offset;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WINDOW = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        pre_win;
    logic [5:0]  pre_top;
    logic        post_win;
    logic [6:0]  win_left;
    logic [6:0]  win_right;
    logic [5:0]  win_top;
    logic [7:0]  pixel_byte;
    logic [5:0]  scroll_line;
  } cmd_t;

endpackage

// File: rtl/core/mpre_front.sv
// Front end: window, cursor and start-line state; turns each request into a command.
module mpre_front import mpre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  req_t       req,
  input  logic [5:0] row_offset,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic       window_valid, window_valid_next;
  logic [6:0] cur_column, cur_column_next;
  logic [2:0] cur_page, cur_page_next;
  logic [6:0] left_bound, left_bound_next;
  logic [6:0] right_bound, right_bound_next;
  logic [2:0] top_page_bound, top_page_bound_next;
  logic [2:0] bottom_page_bound, bottom_page_bound_next;
  logic [5:0] start_line_reg, start_line_reg_next;

  logic [6:0] eff_column;
  logic [2:0] eff_page;
  logic [7:0] col_inc;
  logic [3:0] page_inc;
  logic [2:0] page_step;

  function automatic logic [5:0] top_row(input logic [2:0] page, input logic [5:0] ro,
                                         input logic [5:0] sl);
    logic [7:0] sum;
    sum = {2'b00, page, 3'b000} + {2'b00, ro} + {2'b00, sl};
    return 6'(sum % PANEL_ROWS);
  endfunction

  always_comb begin
    window_valid_next      = window_valid;
    cur_column_next        = cur_column;
    cur_page_next          = cur_page;
    left_bound_next        = left_bound;
    right_bound_next       = right_bound;
    top_page_bound_next    = top_page_bound;
    bottom_page_bound_next = bottom_page_bound;
    start_line_reg_next    = start_line_reg;
    cmd                    = '0;
    cmd_push               = 1'b0;
    eff_column             = cur_column;
    eff_page               = cur_page;
    col_inc                = '0;
    page_inc               = '0;
    page_step              = '0;

    if (take) begin
      case (req.req_type)
        REQ_SET_WINDOW: begin
          left_bound_next        = req.window_left;
          right_bound_next       = req.window_right;
          top_page_bound_next    = req.window_top_page;
          bottom_page_bound_next = req.window_bottom_page;
          cur_page_next          = req.window_top_page;
          cur_column_next        = req.window_left;
          window_valid_next      = 1'b1;
          cmd_push               = 1'b1;
          cmd.kind               = CMD_WINDOW;
          cmd.win_left           = req.window_left;
          cmd.win_right          = req.window_right;
          cmd.win_top            = top_row(req.window_top_page, row_offset, start_line_reg);
        end
        REQ_WRITE_BYTE: begin
          // fall back to the full panel when no window was ever set
          if (!window_valid) begin
            left_bound_next        = '0;
            right_bound_next       = 7'(PANEL_COLUMNS - 1);
            top_page_bound_next    = '0;
            bottom_page_bound_next = 3'(PANEL_PAGES - 1);
            eff_column             = '0;
            eff_page               = '0;
            window_valid_next      = 1'b1;
            cmd.pre_win            = 1'b1;
            cmd.pre_top            = top_row(3'd0, row_offset, start_line_reg);
          end
          cmd_push       = 1'b1;
          cmd.kind       = CMD_BYTE;
          cmd.pixel_byte = req.pixel_byte;
          col_inc        = {1'b0, eff_column} + 8'd1;
          page_inc       = {1'b0, eff_page} + 4'd1;
          page_step      = (page_inc > {1'b0, bottom_page_bound_next}) ?
                           top_page_bound_next : page_inc[2:0];
          if (col_inc > {1'b0, right_bound_next}) begin
            cur_page_next   = page_step;
            cur_column_next = left_bound_next;
            cmd.post_win    = 1'b1;
            cmd.win_left    = left_bound_next;
            cmd.win_right   = right_bound_next;
            cmd.win_top     = top_row(page_step, row_offset, start_line_reg);
          end else begin
            cur_page_next   = eff_page;
            cur_column_next = col_inc[6:0];
          end
        end
        REQ_SCROLL: begin
          // eight rows a page: only the low three page bits survive modulo 64
          start_line_reg_next = 6'(({2'b00, start_line_reg} +
                                    {2'b00, req.scroll_pages[2:0], 3'b000}) % PANEL_ROWS);
          cmd_push        = 1'b1;
          cmd.kind        = CMD_SCROLL;
          cmd.scroll_line = start_line_reg_next;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_valid      <= 1'b0;
      cur_column        <= '0;
      cur_page          <= '0;
      left_bound        <= '0;
      right_bound       <= '0;
      top_page_bound    <= '0;
      bottom_page_bound <= '0;
      start_line_reg    <= '0;
    end else begin
      window_valid      <= window_valid_next;
      cur_column        <= cur_column_next;
      cur_page          <= cur_page_next;
      left_bound        <= left_bound_next;
      right_bound       <= right_bound_next;
      top_page_bound    <= top_page_bound_next;
      bottom_page_bound <= bottom_page_bound_next;
      start_line_reg    <= start_line_reg_next;
    end
  end

endmodule

// File: rtl/core/mpre_cmd_fifo.sv
// Short command queue between the front end and the word sequencer.
module mpre_cmd_fifo import mpre_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic valid,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/mpre_back.sv
// Back end: steps through each command and emits one result word per cycle while commands wait and each word is popped.
module mpre_back import mpre_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  input  cfg_t cfg,
  input  logic pop,
  output logic cmd_pop,
  output res_t res,
  output logic res_valid
);

  logic [3:0] step;
  logic [3:0] eff_pos;
  logic [3:0] pix_pos;
  logic       is_last;
  logic       advance;
  res_t       res_next;

  assign advance = cmd_valid && (!res_valid || pop);
  assign cmd_pop = advance && is_last;
  assign pix_pos = eff_pos - STEP_FIRST_PIXEL;

  always_comb begin
    // skip the default-window word when the command has none
    eff_pos  = (step == STEP_PRE && !cmd.pre_win) ? STEP_FIRST_PIXEL : step;
    is_last  = 1'b1;
    res_next = '0;
    case (cmd.kind)
      CMD_WINDOW: begin
        res_next.result_kind    = KIND_WINDOW;
        res_next.out_left       = cmd.win_left;
        res_next.out_right      = cmd.win_right;
        res_next.out_top_row    = cmd.win_top;
        res_next.out_bottom_row = {1'b0, cmd.win_top} + 7'd7;
      end
      CMD_BYTE: begin
        is_last = (eff_pos == STEP_LAST_PIXEL && !cmd.post_win) || eff_pos == STEP_POST;
        if (eff_pos == STEP_PRE) begin
          res_next.result_kind    = KIND_WINDOW;
          res_next.out_left       = '0;
          res_next.out_right      = 7'(PANEL_COLUMNS - 1);
          res_next.out_top_row    = cmd.pre_top;
          res_next.out_bottom_row = {1'b0, cmd.pre_top} + 7'd7;
        end else if (eff_pos == STEP_POST) begin
          res_next.result_kind    = KIND_WINDOW;
          res_next.out_left       = cmd.win_left;
          res_next.out_right      = cmd.win_right;
          res_next.out_top_row    = cmd.win_top;
          res_next.out_bottom_row = {1'b0, cmd.win_top} + 7'd7;
        end else begin
          res_next.result_kind = KIND_PIXEL;
          res_next.pixel_color = cmd.pixel_byte[pix_pos[2:0]] ?
                                 cfg.foreground_color : cfg.background_color;
        end
      end
      CMD_SCROLL: begin
        res_next.result_kind    = KIND_LINE;
        res_next.out_start_line = cmd.scroll_line;
      end
      default: begin
        res_next = '0;
      end
    endcase
    res_next.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_PRE;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        step      <= is_last ? STEP_PRE : eff_pos + 4'd1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/mono_page_to_rgb565_expander.sv
// Top level of the mono page to RGB565 expander: register port, front end, queue, back end.
//
//   channel   handshake          payload
//   request   push / full        req (req_t)
//   result    pop / empty        res (res_t)
//   config    psel/penable/...   paddr, pwdata, prdata
//
// A set-window or scroll request gives one result word; a write-byte request gives
// eight pixel words plus up to two window words. The result register emits one word
// a cycle while commands are queued and each word is popped.
// Requests enter back to back while the command queue has room (CMD_DEPTH entries).
// Synchronous reset clears the window, cursor, start line, queue and result register.
// A stalled pop holds the result register; the front end keeps filling the queue.
module mono_page_to_rgb565_expander import mpre_pkg::*; #(
  parameter int CMD_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        empty,
  input  logic        pop,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic take;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_valid;
  logic cmd_pop;
  logic res_valid;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign take      = push && !full;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.foreground_color <= 16'hFFFF;
      cfg.background_color <= '0;
      cfg.row_offset       <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FOREGROUND: cfg.foreground_color <= pwdata[15:0];
        REG_BACKGROUND: cfg.background_color <= pwdata[15:0];
        REG_ROW_OFFSET: cfg.row_offset       <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOREGROUND: prdata = {16'd0, cfg.foreground_color};
      REG_BACKGROUND: prdata = {16'd0, cfg.background_color};
      REG_ROW_OFFSET: prdata = {26'd0, cfg.row_offset};
      default:        prdata = '0;
    endcase
  end

  mpre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req        (req),
    .row_offset (cfg.row_offset),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  mpre_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .valid (cmd_valid),
    .full  (full)
  );

  mpre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cfg       (cfg),
    .pop       (pop),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_valid (res_valid)
  );

`ifndef SYNTHESIS
  a_line_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.result_kind == KIND_LINE) |-> res.last)
    else $error("start-line word without last");

  a_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.result_kind == KIND_WINDOW) |->
      res.out_bottom_row == ({1'b0, res.out_top_row} + 7'd7))
    else $error("window bottom row is not top row plus seven");

  a_cols_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.result_kind != KIND_WINDOW) |->
      (res.out_left == '0 && res.out_right == '0))
    else $error("window columns leak into a non-window word");
`endif

endmodule
